@@ rtl/core/modbus_rtu_request_framer_defines.svh @@
// Assertion macros shared by the Modbus RTU request framer RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef MODBUS_RTU_REQUEST_FRAMER_DEFINES_SVH
`define MODBUS_RTU_REQUEST_FRAMER_DEFINES_SVH

// same-cycle implication
`define MRF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MRF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/mrf_pkg.sv @@
// Package for the Modbus RTU request framer: op codes, function codes,
// CRC-16/MODBUS constants, the per-item byte plan type and the CRC step.
package mrf_pkg;

    localparam int OpWidth    = 2;
    localparam int ItemBytes  = 7;
    localparam int NdWidth    = 3;
    localparam int IdxWidth   = 4;
    localparam int InDataW    = 56;

    localparam logic [OpWidth-1:0] OP_READ  = 2'd0;
    localparam logic [OpWidth-1:0] OP_WRITE = 2'd1;
    localparam logic [OpWidth-1:0] OP_VALUE = 2'd2;

    localparam logic [7:0]  FUNC_READ  = 8'h03;
    localparam logic [7:0]  FUNC_WRITE = 8'h10;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;

    typedef struct packed {
        logic [ItemBytes-1:0][7:0] data;
        logic [NdWidth-1:0]        nd;
        logic                      add_crc;
        logic                      restart;
    } t_item;

    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] v;
        v = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (v[0]) begin
                v = (v >> 1) ^ CRC_POLY;
            end else begin
                v = v >> 1;
            end
        end
        return v;
    endfunction

endpackage

@@ rtl/core/mrf_item_decode.sv @@
// Request decode: turns one input beat into a byte plan and tracks the
// open write frame. Depends on mrf_pkg.
module mrf_item_decode (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic                        i_ready,
    input  logic [mrf_pkg::OpWidth-1:0] i_op,
    input  logic [7:0]                  i_unit_id,
    input  logic [15:0]                 i_start_addr,
    input  logic [15:0]                 i_reg_count,
    input  logic [15:0]                 i_wr_word,
    output logic                        o_load,
    output mrf_pkg::t_item              o_item
);

    logic        r_write_open;
    logic [15:0] r_words_left;
    logic        n_write_open;
    logic [15:0] n_words_left;
    logic        accept;
    logic        produces;

    assign accept = i_valid & i_ready;

    always_comb begin
        o_item       = '0;
        produces     = 1'b0;
        n_write_open = r_write_open;
        n_words_left = r_words_left;
        unique case (i_op)
            mrf_pkg::OP_READ, mrf_pkg::OP_WRITE: begin
                produces       = 1'b1;
                o_item.restart = 1'b1;
                o_item.data[0] = i_unit_id;
                o_item.data[1] = (i_op == mrf_pkg::OP_READ) ? mrf_pkg::FUNC_READ
                                                            : mrf_pkg::FUNC_WRITE;
                o_item.data[2] = i_start_addr[15:8];
                o_item.data[3] = i_start_addr[7:0];
                o_item.data[4] = i_reg_count[15:8];
                o_item.data[5] = i_reg_count[7:0];
                o_item.data[6] = {i_reg_count[6:0], 1'b0};
                n_write_open   = 1'b0;
                n_words_left   = '0;
                if (i_op == mrf_pkg::OP_READ) begin
                    o_item.nd      = mrf_pkg::NdWidth'(6);
                    o_item.add_crc = 1'b1;
                end else begin
                    o_item.nd      = mrf_pkg::NdWidth'(7);
                    o_item.add_crc = (i_reg_count == 16'd0);
                    if (i_reg_count != 16'd0) begin
                        n_write_open = 1'b1;
                        n_words_left = i_reg_count;
                    end
                end
            end
            mrf_pkg::OP_VALUE: begin
                if (r_write_open) begin
                    produces       = 1'b1;
                    o_item.data[0] = i_wr_word[15:8];
                    o_item.data[1] = i_wr_word[7:0];
                    o_item.nd      = mrf_pkg::NdWidth'(2);
                    o_item.add_crc = (r_words_left == 16'd1);
                    n_words_left   = r_words_left - 16'd1;
                    n_write_open   = (r_words_left != 16'd1);
                end
            end
            default: begin
                produces = 1'b0;
            end
        endcase
    end

    assign o_load = accept & produces;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_open <= 1'b0;
            r_words_left <= '0;
        end else if (accept) begin
            r_write_open <= n_write_open;
            r_words_left <= n_words_left;
        end
    end

endmodule

@@ rtl/core/mrf_byte_emit.sv @@
// Byte emitter: walks the byte plan one byte a cycle unless stalled, folds data
// bytes into the CRC and appends it. Depends on mrf_pkg and the defines header.
`include "modbus_rtu_request_framer_defines.svh"

module mrf_byte_emit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  mrf_pkg::t_item i_item,
    output logic           o_ready,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_byte,
    output logic           o_last
);

    logic                          r_busy;
    logic [mrf_pkg::IdxWidth-1:0]  r_idx;
    mrf_pkg::t_item                r_item;
    logic [15:0]                   r_crc;
    logic                          r_out_valid;
    logic [7:0]                    r_out_data;
    logic                          r_out_last;

    logic [mrf_pkg::IdxWidth-1:0]  total;
    logic [mrf_pkg::IdxWidth-1:0]  nd_ext;
    logic                          emit;
    logic                          last_byte;
    logic                          fin;
    logic                          is_data;
    logic                          is_crc_lo;
    logic [15:0]                   crc_in;
    logic [7:0]                    n_byte;
    logic [15:0]                   n_crc;

    assign nd_ext    = mrf_pkg::IdxWidth'(r_item.nd);
    assign total     = nd_ext + (r_item.add_crc ? mrf_pkg::IdxWidth'(2)
                                                : mrf_pkg::IdxWidth'(0));
    assign emit      = r_busy & (~r_out_valid | i_ready);
    assign last_byte = (r_idx == total - mrf_pkg::IdxWidth'(1));
    assign fin       = emit & last_byte;
    assign o_ready   = ~r_busy | fin;
    assign is_data   = (r_idx < nd_ext);
    assign is_crc_lo = (r_idx == nd_ext);
    assign crc_in    = (r_idx == '0 && r_item.restart) ? mrf_pkg::CRC_INIT : r_crc;

    always_comb begin
        n_crc  = r_crc;
        n_byte = r_crc[15:8];
        if (is_data) begin
            n_byte = r_item.data[r_idx[mrf_pkg::NdWidth-1:0]];
            n_crc  = mrf_pkg::crc_byte(crc_in, n_byte);
        end else if (is_crc_lo) begin
            n_byte = r_crc[7:0];
        end else begin
            n_crc  = mrf_pkg::CRC_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_crc       <= mrf_pkg::CRC_INIT;
            r_out_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (fin) begin
                r_busy <= 1'b0;
            end else if (emit) begin
                r_idx  <= r_idx + mrf_pkg::IdxWidth'(1);
            end
            if (emit) begin
                r_crc       <= n_crc;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
        if (emit) begin
            r_out_data <= n_byte;
            r_out_last <= ~is_data & ~is_crc_lo;
        end
    end

    assign o_valid = r_out_valid;
    assign o_byte  = r_out_data;
    assign o_last  = r_out_last;

    `MRF_ASSERT_IMP(a_load_when_free, i_clk, i_rst_n, i_load, o_ready,
        "item loaded while plan still running")
    `MRF_ASSERT_IMP(a_crc_slot_planned, i_clk, i_rst_n, r_busy && !is_data, r_item.add_crc,
        "CRC byte emitted for a plan without CRC")
    `MRF_ASSERT_NXT(a_crc_reinit, i_clk, i_rst_n, emit && !is_data && !is_crc_lo,
        r_crc == mrf_pkg::CRC_INIT && r_out_last && r_out_valid,
        "frame end did not reinitialise CRC")

endmodule

@@ rtl/core/modbus_rtu_request_framer.sv @@
// Top level of the Modbus RTU request framer (read 0x03 / write 0x10 + CRC-16).
// Depends on mrf_pkg, mrf_item_decode and mrf_byte_emit.
//
// Channel  Dir  tdata (low bit up)                              tuser    tlast
// s        in   unit_id[7:0] start_addr[23:8] reg_count[39:24]  op[1:0]  -
//               wr_word[55:40]
// m        out  frame_byte[7:0]                                 -        frame_end
//
// One frame byte leaves per cycle through a registered output stage while m is not stalled.
// A read request yields 8 bytes, a write header 7 (9 with a zero count),
// a register value 2 (4 when it closes the frame); items yielding no
// bytes produce no output. The next item is taken in the cycle its
// predecessor's last byte enters the output register.
// Synchronous active-low reset, tready low while in reset; a stall on m holds the output byte.
module modbus_rtu_request_framer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [mrf_pkg::InDataW-1:0]  i_s_tdata,   // unit_id, start_addr, reg_count, wr_word
    input  logic [mrf_pkg::OpWidth-1:0]  i_s_tuser,   // op
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [7:0]                   o_m_tdata,   // frame_byte
    output logic                         o_m_tlast
);

    logic           load;
    logic           emit_ready;
    mrf_pkg::t_item item;

    assign o_s_tready = emit_ready & i_rst_n;

    mrf_item_decode u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_tvalid),
        .i_ready      (o_s_tready),
        .i_op         (i_s_tuser),
        .i_unit_id    (i_s_tdata[7:0]),
        .i_start_addr (i_s_tdata[23:8]),
        .i_reg_count  (i_s_tdata[39:24]),
        .i_wr_word    (i_s_tdata[55:40]),
        .o_load       (load),
        .o_item       (item)
    );

    mrf_byte_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_item  (item),
        .o_ready (emit_ready),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_byte  (o_m_tdata),
        .o_last  (o_m_tlast)
    );

endmodule
